// ===== rtl/text_mode_console_writer_defines.svh =====
// Assertion macros shared by the console writer checks.
`ifndef TEXT_MODE_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_MODE_CONSOLE_WRITER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TMCW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tmcw: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TMCW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tmcw: next-cycle check failed");

`endif

// ===== rtl/tmcw_pkg.sv =====
// Types, codes and constants of the text-mode console writer.
package tmcw_pkg;

  localparam int MAX_COLUMNS  = 80;
  localparam int MAX_ROWS     = 25;
  localparam int MEMORY_DEPTH = 2048;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ATTR_W = 7;
  localparam int CHAR_W = 8;
  localparam int CADR_W = 11;
  localparam int LOC_W  = 11;
  localparam int CELL_W = 16;

  // operation codes
  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_SET   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_COLUMNS = 2'd0;
  localparam logic [1:0] REG_ROWS    = 2'd1;
  localparam logic [1:0] REG_ATTR    = 2'd2;
  localparam logic [1:0] REG_SHOWN   = 2'd3;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;
  localparam logic [CELL_W-1:0] RESET_CELL   = 16'h0720;

  localparam logic [COL_W-1:0]  RST_COLUMNS = 7'd80;
  localparam logic [ROW_W-1:0]  RST_ROWS    = 5'd25;
  localparam logic [ATTR_W-1:0] RST_ATTR    = 7'd7;

  typedef struct packed {
    logic [1:0]              func;
    logic [CHAR_W-1:0]       char_code;
    logic signed [7:0]       col_x;
    logic signed [7:0]       row_y;
    logic [CADR_W-1:0]       cell_address;
  } tmcw_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] echo_char;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [LOC_W-1:0]  cursor_location;
    logic              cursor_written;
    logic              scrolled;
    logic [CELL_W-1:0] cell_value;
  } tmcw_out_t;

  typedef struct packed {
    logic [1:0]        index;
    logic [ATTR_W-1:0] data;
  } tmcw_cfg_t;

endpackage

// ===== rtl/tmcw_stream_if.sv =====
// Valid/ready channel carrying one word of type T.
interface tmcw_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/text_mode_console_writer.sv =====
// Text-mode console writer: cell memory, cursor, put/set/clear/read operations.
// Set cursor goes S_CLAMP, S_LOC, S_FIN; read cell S_READ, S_LOC, S_FIN; put char S_CLAMP,
// S_ADDR, S_PUT, S_LOC, S_FIN. A scrolling put copies rows up, then blanks the last row;
// a clear blanks cols*rows cells. One item at a time: the next accept can come once the
// result word is registered; an unread result word holds the next one back.
// rst_ni async clears cursor and control, loads config reset values; a RESET_CELL pass follows.
module text_mode_console_writer import tmcw_pkg::*; #(
  parameter int MaxColumns  = MAX_COLUMNS,
  parameter int MaxRows     = MAX_ROWS,
  parameter int MemoryDepth = MEMORY_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tmcw_stream_if.sink   in_i,
  tmcw_stream_if.source out_o,
  tmcw_stream_if.sink   cfg_i
);

  localparam int AW     = $clog2(MemoryDepth);
  localparam int MacW   = $clog2(32 * MaxColumns + 128);
  localparam int DepthW = $clog2(MemoryDepth + 1);
  localparam int IdxW0  = (MacW > DepthW) ? MacW : DepthW;
  localparam int IdxW   = (IdxW0 > 12) ? IdxW0 : 12;

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_CLAMP  = 4'd2;
  localparam logic [3:0] S_ADDR   = 4'd3;
  localparam logic [3:0] S_PUT    = 4'd4;
  localparam logic [3:0] S_TOTAL  = 4'd5;
  localparam logic [3:0] S_SCR_RD = 4'd6;
  localparam logic [3:0] S_SCR_WR = 4'd7;
  localparam logic [3:0] S_FILL   = 4'd8;
  localparam logic [3:0] S_READ   = 4'd9;
  localparam logic [3:0] S_LOC    = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;

  logic [3:0]        state_q, state_d;
  logic [COL_W-1:0]  cur_col_q, cur_col_d;
  logic [ROW_W-1:0]  cur_row_q, cur_row_d;
  logic [COL_W-1:0]  columns_q;
  logic [ROW_W-1:0]  rows_q;
  logic [ATTR_W-1:0] attr_q;
  logic              shown_q;
  tmcw_in_t          item_q, item_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [IdxW-1:0]   mac_q, mac_d;
  logic              scrolled_q, scrolled_d;
  logic [CELL_W-1:0] cell_q, cell_d;
  logic              rd_ok_q, rd_ok_d;
  logic              out_valid_q, out_valid_d;
  tmcw_out_t         out_data_q, out_data_d;

  logic [CELL_W-1:0] mem_q [MemoryDepth];
  logic [CELL_W-1:0] rdata_q;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata;

  logic [COL_W-1:0]  cols_eff;
  logic [ROW_W-1:0]  rows_eff;
  logic [ROW_W-1:0]  mac_a;
  logic [COL_W-1:0]  mac_b;
  logic [IdxW-1:0]   mac_res;
  logic [IdxW-1:0]   scr_src, scr_moved, cadr_ext;
  logic [COL_W:0]    col_inc;
  logic [ROW_W:0]    row_inc;
  logic [CELL_W-1:0] blank;
  logic              row_adv;

  // effective geometry: zero reads as one, oversize as the maximum
  always_comb begin
    if (columns_q == '0) begin
      cols_eff = COL_W'(1);
    end else if ({1'b0, columns_q} > (COL_W+1)'(MaxColumns)) begin
      cols_eff = COL_W'(MaxColumns);
    end else begin
      cols_eff = columns_q;
    end
    if (rows_q == '0) begin
      rows_eff = ROW_W'(1);
    end else if ({1'b0, rows_q} > (ROW_W+1)'(MaxRows)) begin
      rows_eff = ROW_W'(MaxRows);
    end else begin
      rows_eff = rows_q;
    end
  end

  // shared multiply-add unit: a * cols + b
  always_comb begin
    if (state_q == S_TOTAL) begin
      mac_a = rows_eff;
      mac_b = '0;
    end else begin
      mac_a = cur_row_q;
      mac_b = cur_col_q;
    end
    mac_res = IdxW'(mac_a) * IdxW'(cols_eff) + IdxW'(mac_b);
  end

  assign blank     = {1'b0, attr_q, BLANK_CODE};
  assign scr_src   = idx_q + IdxW'(cols_eff);
  assign scr_moved = mac_q - IdxW'(cols_eff);
  assign cadr_ext  = IdxW'(in_i.data.cell_address);
  assign col_inc   = {1'b0, cur_col_q} + (COL_W+1)'(1);
  assign row_inc   = {1'b0, cur_row_q} + (ROW_W+1)'(1);

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  always_comb begin
    state_d     = state_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    item_d      = item_q;
    idx_d       = idx_q;
    mac_d       = mac_q;
    scrolled_d  = scrolled_q;
    cell_d      = cell_q;
    rd_ok_d     = rd_ok_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q[AW-1:0];
    mem_wdata   = blank;
    mem_raddr   = '0;
    row_adv     = 1'b0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = RESET_CELL;
        if (idx_q == IdxW'(MemoryDepth - 1)) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      S_IDLE: begin
        mem_raddr = cadr_ext[AW-1:0];
        if (in_i.valid) begin
          item_d     = in_i.data;
          scrolled_d = 1'b0;
          cell_d     = '0;
          rd_ok_d    = cadr_ext < IdxW'(MemoryDepth);
          case (in_i.data.func)
            FUNC_PUT, FUNC_SET: state_d = S_CLAMP;
            FUNC_CLEAR:         state_d = S_TOTAL;
            default:            state_d = S_READ;
          endcase
        end
      end
      S_CLAMP: begin
        if (item_q.func == FUNC_PUT) begin
          if (cur_col_q >= cols_eff) cur_col_d = cols_eff - COL_W'(1);
          if (cur_row_q >= rows_eff) cur_row_d = rows_eff - ROW_W'(1);
          state_d = S_ADDR;
        end else begin
          if (item_q.col_x < 0) begin
            cur_col_d = '0;
          end else if ({1'b0, item_q.col_x[6:0]} >= {1'b0, cols_eff}) begin
            cur_col_d = cols_eff - COL_W'(1);
          end else begin
            cur_col_d = item_q.col_x[6:0];
          end
          if (item_q.row_y < 0) begin
            cur_row_d = '0;
          end else if (item_q.row_y[6:0] >= 7'(rows_eff)) begin
            cur_row_d = rows_eff - ROW_W'(1);
          end else begin
            cur_row_d = item_q.row_y[ROW_W-1:0];
          end
          state_d = S_LOC;
        end
      end
      S_ADDR: begin
        mac_d   = mac_res;
        state_d = S_PUT;
      end
      S_PUT: begin
        if (item_q.char_code == NEWLINE_CODE) begin
          cur_col_d = '0;
          row_adv   = 1'b1;
        end else begin
          mem_we    = mac_q < IdxW'(MemoryDepth);
          mem_waddr = mac_q[AW-1:0];
          mem_wdata = {1'b0, attr_q, item_q.char_code};
          if (col_inc == (COL_W+1)'(cols_eff)) begin
            cur_col_d = '0;
            row_adv   = 1'b1;
          end else begin
            cur_col_d = col_inc[COL_W-1:0];
          end
        end
        state_d = S_LOC;
        if (row_adv) begin
          if (row_inc == (ROW_W+1)'(rows_eff)) begin
            // bottom reached: row stays on the last line, screen moves up
            scrolled_d = 1'b1;
            state_d    = S_TOTAL;
          end else begin
            cur_row_d = row_inc[ROW_W-1:0];
          end
        end
      end
      S_TOTAL: begin
        mac_d = mac_res;
        idx_d = '0;
        state_d = (item_q.func == FUNC_CLEAR) ? S_FILL : S_SCR_RD;
      end
      S_SCR_RD: begin
        mem_raddr = scr_src[AW-1:0];
        rd_ok_d   = scr_src < IdxW'(MemoryDepth);
        state_d   = (idx_q >= scr_moved) ? S_FILL : S_SCR_WR;
      end
      S_SCR_WR: begin
        mem_we    = idx_q < IdxW'(MemoryDepth);
        mem_wdata = rd_ok_q ? rdata_q : '0;
        idx_d     = idx_q + IdxW'(1);
        state_d   = S_SCR_RD;
      end
      S_FILL: begin
        if (idx_q >= mac_q) begin
          state_d = S_LOC;
        end else begin
          mem_we = idx_q < IdxW'(MemoryDepth);
          idx_d  = idx_q + IdxW'(1);
        end
      end
      S_READ: begin
        cell_d  = rd_ok_q ? rdata_q : '0;
        state_d = S_LOC;
      end
      S_LOC: begin
        mac_d   = mac_res;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d                = 1'b1;
          out_data_d.echo_char       = (item_q.func == FUNC_PUT) ? item_q.char_code : '0;
          out_data_d.cursor_col      = cur_col_q;
          out_data_d.cursor_row      = cur_row_q;
          out_data_d.cursor_location = LOC_W'(mac_q);
          out_data_d.cursor_written  = (item_q.func == FUNC_PUT || item_q.func == FUNC_SET)
                                       ? shown_q : 1'b0;
          out_data_d.scrolled        = scrolled_q;
          out_data_d.cell_value      = cell_q;
          state_d                    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      columns_q   <= RST_COLUMNS;
      rows_q      <= RST_ROWS;
      attr_q      <= RST_ATTR;
      shown_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        case (cfg_i.data.index)
          REG_COLUMNS: columns_q <= cfg_i.data.data[COL_W-1:0];
          REG_ROWS:    rows_q    <= cfg_i.data.data[ROW_W-1:0];
          REG_ATTR:    attr_q    <= cfg_i.data.data;
          REG_SHOWN:   shown_q   <= cfg_i.data.data[0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    mac_q      <= mac_d;
    scrolled_q <= scrolled_d;
    cell_q     <= cell_d;
    rd_ok_q    <= rd_ok_d;
    out_data_q <= out_data_d;
  end

  // cell memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

endmodule

// ===== rtl/tmcw_checker.sv =====
// Port-level checks of the console writer, bound to the top level.
`include "text_mode_console_writer_defines.svh"

module tmcw_checker import tmcw_pkg::*; #(
  parameter int MaxRows = MAX_ROWS
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input tmcw_out_t out_data_i
);

  // a stalled result word stays up and unchanged
  `TMCW_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  `TMCW_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i, $stable(out_data_i))

  // one item at a time: busy right after an accept
  `TMCW_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_i, !in_ready_i)

  // reported cursor row never reaches the row limit
  `TMCW_ASSERT_NOW(a_row_range, out_valid_i, 6'(out_data_i.cursor_row) < 6'(MaxRows))

endmodule

bind text_mode_console_writer tmcw_checker #(
  .MaxRows(MaxRows)
) u_tmcw_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_data_i (out_o.data)
);
